FILE: rtl/sbie_pkg.sv
// Shared constants, types and a helper function of the bytecode executor.
package sbie_pkg;

   localparam int STACK_DEPTH_DEF  = 16;
   localparam int LOCALS_DEPTH_DEF = 256;
   localparam int PC_BITS_DEF      = 16;
   localparam int WORD_W           = 32;
   localparam int PC_OUT_W         = 16;
   localparam int LIMIT_W          = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNDER   = 3'd1;
   localparam logic [2:0] ST_OVER    = 3'd2;
   localparam logic [2:0] ST_DIVZ    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_INVOKE  = 3'd5;

   localparam logic [7:0] OP_ICONST_FIRST  = 8'h02;
   localparam logic [7:0] OP_ICONST_LAST   = 8'h08;
   localparam logic [7:0] OP_CONST_BASE    = 8'h03;
   localparam logic [7:0] OP_BIPUSH        = 8'h10;
   localparam logic [7:0] OP_SIPUSH        = 8'h11;
   localparam logic [7:0] OP_LDC           = 8'h12;
   localparam logic [7:0] OP_ILOAD         = 8'h15;
   localparam logic [7:0] OP_LOAD_BASE     = 8'h1a;
   localparam logic [7:0] OP_ISTORE        = 8'h36;
   localparam logic [7:0] OP_STORE_BASE    = 8'h3b;
   localparam logic [7:0] OP_ARITH_BASE    = 8'h60;
   localparam logic [7:0] OP_ARITH_LAST    = 8'h70;
   localparam logic [7:0] OP_INEG          = 8'h74;
   localparam logic [7:0] OP_IINC          = 8'h84;
   localparam logic [7:0] OP_IFZ_BASE      = 8'h99;
   localparam logic [7:0] OP_IFCMP_BASE    = 8'h9f;
   localparam logic [7:0] OP_GOTO          = 8'ha7;
   localparam logic [7:0] OP_IRETURN       = 8'hac;
   localparam logic [7:0] OP_RETURN        = 8'hb1;
   localparam logic [7:0] OP_GETSTATIC     = 8'hb2;
   localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hb6;
   localparam logic [7:0] OP_INVOKESTATIC  = 8'hb8;

   localparam logic [2:0] AR_ADD = 3'd0;
   localparam logic [2:0] AR_SUB = 3'd1;
   localparam logic [2:0] AR_MUL = 3'd2;
   localparam logic [2:0] AR_DIV = 3'd3;
   localparam logic [2:0] AR_REM = 3'd4;

   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_GE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;

   typedef struct packed {
      logic [PC_OUT_W-1:0] next_pc;
      logic                finished;
      logic                return_valid;
      logic                print_valid;
      logic [WORD_W-1:0]   result_value;
      logic [2:0]          status;
   } sbie_result_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } sbie_div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] remainder;
   } sbie_div_rsp_type;

   function automatic logic cmp_sel(input logic [2:0] sel, input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] b);
      logic lt;
      logic eq;
      lt = $signed(a) < $signed(b);
      eq = a == b;
      unique case (sel)
         CMP_EQ:  cmp_sel = eq;
         CMP_NE:  cmp_sel = !eq;
         CMP_LT:  cmp_sel = lt;
         CMP_GE:  cmp_sel = !lt;
         CMP_GT:  cmp_sel = !lt && !eq;
         default: cmp_sel = lt || eq;
      endcase
   endfunction

endpackage

FILE: rtl/sbie_if.sv
// Handshake channel interfaces for instruction words, result words and the limit register.
interface sbie_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic [7:0]  operand_high;
   logic [7:0]  operand_low;
   logic [31:0] pool_constant;
   modport source(output valid, opcode, operand_high, operand_low, pool_constant,
                  input ready);
   modport sink(input valid, opcode, operand_high, operand_low, pool_constant,
                output ready);
endinterface

interface sbie_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        finished;
   logic        return_valid;
   logic        print_valid;
   logic [31:0] result_value;
   logic [2:0]  status;
   modport source(output valid, next_pc, finished, return_valid, print_valid, result_value,
                  status, input ready);
   modport sink(input valid, next_pc, finished, return_valid, print_valid, result_value,
                status, output ready);
endinterface

interface sbie_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] stack_limit;
   modport source(output valid, stack_limit, input ready);
   modport sink(input valid, stack_limit, output ready);
endinterface

FILE: rtl/sbie_divider.sv
// Radix-2 restoring signed divider giving the truncated quotient and remainder.
module sbie_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  sbie_pkg::sbie_div_req_type div_req,
   output sbie_pkg::sbie_div_rsp_type div_rsp
);
   import sbie_pkg::*;

   localparam int CNT_W = $clog2(WORD_W) + 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic              qneg_ff, qneg_in;
   logic              rneg_ff, rneg_in;
   logic [WORD_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      trial   = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, div_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend[WORD_W-1] ? -div_req.dividend : div_req.dividend;
         div_in  = div_req.divisor[WORD_W-1] ? -div_req.divisor : div_req.divisor;
         qneg_in = div_req.dividend[WORD_W-1] ^ div_req.divisor[WORD_W-1];
         rneg_in = div_req.dividend[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = qneg_ff ? -quo_ff : quo_ff;
   assign div_rsp.remainder = rneg_ff ? -rem_ff : rem_ff;

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy)
      else $error("divider done without a running division");

   property p_no_start_while_busy;
      @(posedge clock) disable iff (reset) busy_ff |-> !div_req.start;
   endproperty
   a_no_start_while_busy: assert property (p_no_start_while_busy)
      else $error("divider restarted while busy");

   property p_busy_not_done;
      @(posedge clock) disable iff (reset) done_ff |-> !busy_ff;
   endproperty
   a_busy_not_done: assert property (p_busy_not_done)
      else $error("divider done and busy together");

endmodule

FILE: rtl/stack_bytecode_integer_executor_top.sv
// Top level of the integer bytecode executor: stack and local memories and the step sequencer.
// The req_bus channel takes one instruction word per item: the opcode, the two code bytes
// that follow it and, for ldc, the resolved pool constant. For every instruction word the
// block returns exactly one result word on rsp_bus with the next pc, the finished, return
// and print flags, the printed or returned value and an error status.
// An instruction is read and then executed: the operand stack and the locals memory are read
// as the word is accepted, and it executes and writes back in the execute state; a new word
// is accepted only once the block is idle again. Division and remainder run on a bit-serial
// divider; the block waits for it, writes the result back and goes through the output state.
// The result sits in an output register; the next instruction word is accepted while it
// waits. If the receiver stalls and a second result is ready, the block holds that result
// and accepts nothing more until the output register drains.
// The csr_bus channel writes the operand stack limit and is always ready; write it only
// while the block is idle.
// Reset clears the pc, the stack count and the valid bits of the locals, which then read
// as zero, and sets the stack limit to 16. No clearing pass is needed.
module stack_bytecode_integer_executor_top #(
   parameter int STACK_DEPTH  = sbie_pkg::STACK_DEPTH_DEF,
   parameter int LOCALS_DEPTH = sbie_pkg::LOCALS_DEPTH_DEF,
   parameter int PC_BITS      = sbie_pkg::PC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   sbie_req_if.sink   req_bus,
   sbie_rsp_if.source rsp_bus,
   sbie_csr_if.sink   csr_bus
);
   import sbie_pkg::*;

   localparam int SI   = $clog2(STACK_DEPTH);
   localparam int CS   = SI + 1;
   localparam int LI   = $clog2(LOCALS_DEPTH);
   localparam int CW   = (CS > LIMIT_W) ? CS : LIMIT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   logic [CS-1:0]       cnt_ff, cnt_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [7:0]          op_ff, hi_ff, lo_ff;
   logic [WORD_W-1:0]   pool_ff;

   logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0]   s1_ff, s2_ff;
   logic [WORD_W-1:0]   loc_mem [LOCALS_DEPTH];
   logic [LOCALS_DEPTH-1:0] loc_vld_ff;
   logic [WORD_W-1:0]   lrd_ff;
   logic                lrd_ok_ff;

   sbie_result_type     res, res_ff, rsp_ff;
   logic                rsp_vld_ff;
   logic                rsp_free;
   logic                req_acc;

   logic [CS-1:0]       cm1, cm2;
   logic [7:0]          lr_idx;
   logic                lr_in_range;
   logic [7:0]          lw_idx;
   logic                lw_in_range;

   logic                st_we;
   logic [SI-1:0]       st_wa;
   logic [WORD_W-1:0]   st_wd;
   logic                lw_we;
   logic [WORD_W-1:0]   lw_wd;

   logic                push_req;
   logic [WORD_W-1:0]   push_val;
   logic                div_go;
   logic [PC_BITS-1:0]  npc;
   logic [15:0]         word16;
   logic [WORD_W-1:0]   lv;
   logic                has1, has2, full;
   logic [2:0]          sel;

   sbie_div_req_type    div_req;
   sbie_div_rsp_type    div_rsp;

   sbie_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_bus.ready = state_ff == S_IDLE;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_free      = !rsp_vld_ff || rsp_bus.ready;

   assign cm1 = cnt_ff - CS'(1);
   assign cm2 = cnt_ff - CS'(2);

   assign lr_idx = (req_bus.opcode >= OP_LOAD_BASE && req_bus.opcode <= OP_LOAD_BASE + 8'd3)
                   ? req_bus.opcode - OP_LOAD_BASE : req_bus.operand_high;
   assign lr_in_range = {1'b0, lr_idx} < 9'(LOCALS_DEPTH);
   assign lw_idx = (op_ff >= OP_STORE_BASE && op_ff <= OP_STORE_BASE + 8'd3)
                   ? op_ff - OP_STORE_BASE : hi_ff;
   assign lw_in_range = {1'b0, lw_idx} < 9'(LOCALS_DEPTH);

   assign lv     = lrd_ok_ff ? lrd_ff : '0;
   assign word16 = {hi_ff, lo_ff};
   assign has1   = cnt_ff != '0;
   assign has2   = cnt_ff >= CS'(2);
   assign full   = (CW'(cnt_ff) >= CW'(limit_ff)) || (cnt_ff >= CS'(STACK_DEPTH));
   assign sel    = 3'((op_ff - OP_ARITH_BASE) >> 2);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      cnt_in   = cnt_ff;
      st_we    = 1'b0;
      st_wa    = cm1[SI-1:0];
      st_wd    = '0;
      lw_we    = 1'b0;
      lw_wd    = '0;
      push_req = 1'b0;
      push_val = '0;
      div_go   = 1'b0;
      npc      = pc_ff + PC_BITS'(1);
      res      = '0;
      div_req.start    = 1'b0;
      div_req.dividend = s2_ff;
      div_req.divisor  = s1_ff;

      priority if (op_ff >= OP_ICONST_FIRST && op_ff <= OP_ICONST_LAST) begin
         push_req = 1'b1;
         push_val = {24'd0, op_ff} - {24'd0, OP_CONST_BASE};
      end else if (op_ff >= OP_LOAD_BASE && op_ff <= OP_LOAD_BASE + 8'd3) begin
         push_req = 1'b1;
         push_val = lv;
      end else if (op_ff >= OP_STORE_BASE && op_ff <= OP_STORE_BASE + 8'd3) begin
         if (!has1) begin
            res.status = ST_UNDER;
         end else begin
            cnt_in = cm1;
            lw_we  = lw_in_range;
            lw_wd  = s1_ff;
         end
      end else if (op_ff >= OP_ARITH_BASE && op_ff <= OP_ARITH_LAST && op_ff[1:0] == 2'b00)
      begin
         if (!has2) begin
            res.status = ST_UNDER;
         end else if ((sel == AR_DIV || sel == AR_REM) && s1_ff == '0) begin
            res.status = ST_DIVZ;
         end else if (sel == AR_DIV || sel == AR_REM) begin
            div_go        = 1'b1;
            div_req.start = 1'b1;
         end else begin
            st_we  = 1'b1;
            st_wa  = cm2[SI-1:0];
            cnt_in = cm1;
            unique case (sel)
               AR_ADD:  st_wd = s2_ff + s1_ff;
               AR_SUB:  st_wd = s2_ff - s1_ff;
               default: st_wd = s2_ff * s1_ff;
            endcase
         end
      end else if (op_ff >= OP_IFZ_BASE && op_ff <= OP_IFZ_BASE + 8'd5) begin
         npc = pc_ff + PC_BITS'(3);
         if (!has1) begin
            res.status = ST_UNDER;
         end else begin
            cnt_in = cm1;
            if (cmp_sel(3'(op_ff - OP_IFZ_BASE), s1_ff, '0)) begin
               npc = pc_ff + word16[PC_BITS-1:0];
            end
         end
      end else if (op_ff >= OP_IFCMP_BASE && op_ff <= OP_IFCMP_BASE + 8'd5) begin
         npc = pc_ff + PC_BITS'(3);
         if (!has2) begin
            res.status = ST_UNDER;
         end else begin
            cnt_in = cm2;
            if (cmp_sel(3'(op_ff - OP_IFCMP_BASE), s2_ff, s1_ff)) begin
               npc = pc_ff + word16[PC_BITS-1:0];
            end
         end
      end else begin
         unique case (op_ff)
            OP_BIPUSH: begin
               push_req = 1'b1;
               push_val = {{24{hi_ff[7]}}, hi_ff};
               npc      = pc_ff + PC_BITS'(2);
            end
            OP_SIPUSH: begin
               push_req = 1'b1;
               push_val = {{16{word16[15]}}, word16};
               npc      = pc_ff + PC_BITS'(3);
            end
            OP_LDC: begin
               push_req = 1'b1;
               push_val = pool_ff;
               npc      = pc_ff + PC_BITS'(2);
            end
            OP_ILOAD: begin
               push_req = 1'b1;
               push_val = lv;
               npc      = pc_ff + PC_BITS'(2);
            end
            OP_ISTORE: begin
               npc = pc_ff + PC_BITS'(2);
               if (!has1) begin
                  res.status = ST_UNDER;
               end else begin
                  cnt_in = cm1;
                  lw_we  = lw_in_range;
                  lw_wd  = s1_ff;
               end
            end
            OP_INEG: begin
               if (!has1) begin
                  res.status = ST_UNDER;
               end else begin
                  st_we = 1'b1;
                  st_wd = -s1_ff;
               end
            end
            OP_IINC: begin
               npc   = pc_ff + PC_BITS'(3);
               lw_we = lw_in_range;
               lw_wd = lv + {{24{lo_ff[7]}}, lo_ff};
            end
            OP_GOTO: npc = pc_ff + word16[PC_BITS-1:0];
            OP_IRETURN: begin
               res.finished = 1'b1;
               if (!has1) begin
                  res.status = ST_UNDER;
               end else begin
                  res.result_value = s1_ff;
                  res.return_valid = 1'b1;
               end
            end
            OP_RETURN: res.finished = 1'b1;
            OP_GETSTATIC: npc = pc_ff + PC_BITS'(3);
            OP_INVOKEVIRTUAL: begin
               npc = pc_ff + PC_BITS'(3);
               if (!has1) begin
                  res.status = ST_UNDER;
               end else begin
                  cnt_in           = cm1;
                  res.result_value = s1_ff;
                  res.print_valid  = 1'b1;
               end
            end
            OP_INVOKESTATIC: begin
               npc        = pc_ff + PC_BITS'(3);
               res.status = ST_INVOKE;
            end
            default: res.status = ST_UNKNOWN;
         endcase
      end

      if (push_req) begin
         if (full) begin
            res.status = ST_OVER;
         end else begin
            st_we  = 1'b1;
            st_wa  = cnt_ff[SI-1:0];
            st_wd  = push_val;
            cnt_in = cnt_ff + CS'(1);
         end
      end

      if (res.finished) begin
         npc    = '0;
         cnt_in = '0;
      end
      res.next_pc = PC_OUT_W'(npc);

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = cnt_ff;
            st_we  = 1'b0;
            lw_we  = 1'b0;
            div_req.start = 1'b0;
            if (req_acc) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            pc_in = npc;
            if (div_go) begin
               state_in = S_DIV;
            end else if (rsp_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff;
            st_we  = 1'b0;
            lw_we  = 1'b0;
            div_req.start = 1'b0;
            if (div_rsp.done) begin
               st_we    = 1'b1;
               st_wa    = cm2[SI-1:0];
               st_wd    = (sel == AR_DIV) ? div_rsp.quotient : div_rsp.remainder;
               cnt_in   = cm1;
               state_in = S_OUT;
            end
         end
         default: begin
            cnt_in = cnt_ff;
            st_we  = 1'b0;
            lw_we  = 1'b0;
            div_req.start = 1'b0;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pc_ff      <= '0;
         cnt_ff     <= '0;
         limit_ff   <= LIMIT_RESET;
         loc_vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         if (csr_bus.valid) begin
            limit_ff <= csr_bus.stack_limit;
         end
         if (lw_we) begin
            loc_vld_ff[lw_idx[LI-1:0]] <= 1'b1;
         end
         if (state_ff == S_EXEC && !div_go && rsp_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (state_ff == S_OUT && rsp_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff   <= req_bus.opcode;
         hi_ff   <= req_bus.operand_high;
         lo_ff   <= req_bus.operand_low;
         pool_ff <= req_bus.pool_constant;
      end
      if (state_ff == S_EXEC) begin
         res_ff <= res;
      end
      if (state_ff == S_EXEC && !div_go && rsp_free) begin
         rsp_ff <= res;
      end else if (state_ff == S_OUT && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= stack_mem[cm1[SI-1:0]];
      s2_ff <= stack_mem[cm2[SI-1:0]];
      if (st_we) begin
         stack_mem[st_wa] <= st_wd;
      end
   end

   always_ff @(posedge clock) begin
      lrd_ff    <= loc_mem[lr_idx[LI-1:0]];
      lrd_ok_ff <= lr_in_range && loc_vld_ff[lr_idx[LI-1:0]];
      if (lw_we) begin
         loc_mem[lw_idx[LI-1:0]] <= lw_wd;
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.next_pc      = rsp_ff.next_pc;
   assign rsp_bus.finished     = rsp_ff.finished;
   assign rsp_bus.return_valid = rsp_ff.return_valid;
   assign rsp_bus.print_valid  = rsp_ff.print_valid;
   assign rsp_bus.result_value = rsp_ff.result_value;
   assign rsp_bus.status       = rsp_ff.status;

   property p_cnt_bound;
      @(posedge clock) disable iff (reset) cnt_ff <= CS'(STACK_DEPTH);
   endproperty
   a_cnt_bound: assert property (p_cnt_bound)
      else $error("stack count beyond the stack depth");

   property p_finish_pc;
      @(posedge clock) disable iff (reset)
         rsp_bus.valid && rsp_bus.finished |-> rsp_bus.next_pc == '0;
   endproperty
   a_finish_pc: assert property (p_finish_pc)
      else $error("finished word with a nonzero pc");

   property p_accept_exec;
      @(posedge clock) disable iff (reset) req_acc |=> state_ff == S_EXEC;
   endproperty
   a_accept_exec: assert property (p_accept_exec)
      else $error("accepted word not executed");

   property p_div_start;
      @(posedge clock) disable iff (reset) div_req.start |-> has2 && s1_ff != '0;
   endproperty
   a_div_start: assert property (p_div_start)
      else $error("divider started without a valid divisor");

endmodule
